FILE: rtl/core/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, result codes and character helpers of the hex image loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam logic [3:0] CODE_OK     = 4'd0;
   localparam logic [3:0] CODE_EMPTY  = 4'd1;
   localparam logic [3:0] CODE_COLON  = 4'd2;
   localparam logic [3:0] CODE_ODD    = 4'd3;
   localparam logic [3:0] CODE_SUM    = 4'd4;
   localparam logic [3:0] CODE_LENGTH = 4'd5;
   localparam logic [3:0] CODE_TYPE   = 4'd6;
   localparam logic [3:0] CODE_RANGE  = 4'd7;
   localparam logic [3:0] CODE_DIGIT  = 4'd8;

   localparam logic [7:0] REC_DATA  = 8'h00;
   localparam logic [7:0] REC_UPPER = 8'h04;
   localparam logic [7:0] REC_START = 8'h05;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] ERASED     = 8'hFF;

   localparam logic [9:0] DIGIT_CAP = 10'd1023;
   localparam logic [9:0] EOF_DIGITS = 10'd10;

   typedef struct packed {
      logic clear_wr;
      logic take_char;
      logic read_img;
      logic rsp_plain;
      logic rsp_read;
      logic eval1;
      logic eval2;
      logic copy_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic item_read;
      logic item_eol;
      logic copy_go;
      logic copy_done;
   } dp_status_type;

   // {bad, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
      else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         r = {1'b0, c[3:0] + 4'd9};
      return r;
   endfunction

   // character expected at digit position i of the end-of-file record
   function automatic logic [7:0] eof_next_char(input logic [3:0] i);
      logic [7:0] r;
      case (i)
         4'd7:       r = 8'h31;
         4'd8, 4'd9: r = 8'h46;
         default:    r = 8'h30;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/core/ihex_dp.sv
// ----------------------------------------------------------------------------
// ihex_dp
// Datapath: line parser registers, record store, image store, result register.
// ----------------------------------------------------------------------------
module ihex_dp #(
   parameter int IMAGE_BYTES      = 65536,
   parameter int MAX_RECORD_BYTES = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ihex_pkg::dp_cmd_type   cmd,
   output ihex_pkg::dp_status_type st,
   input  logic [23:0]            req_tdata,
   input  logic                   req_tuser,
   input  logic                   csr_valid,
   input  logic [31:0]            csr_data,
   output logic                   line_done,
   output logic [3:0]             line_code,
   output logic [3:0]             overall_code,
   output logic                   finished,
   output logic [7:0]             read_data
);
   import ihex_pkg::*;

   localparam int IW = (IMAGE_BYTES > 1) ? $clog2(IMAGE_BYTES) : 1;
   localparam int RW = $clog2(MAX_RECORD_BYTES);

   logic [7:0]  c;
   logic [15:0] read_addr;
   assign c         = req_tdata[7:0];
   assign read_addr = req_tdata[23:8];

   logic [7:0] image_mem [IMAGE_BYTES];
   logic [7:0] rec_mem [MAX_RECORD_BYTES];

   logic [31:0]   base_ff;
   logic [IW-1:0] clr_ff;
   logic [15:0]   upper_ff;
   logic          seen_ff, bad_ff, eofm_ff;
   logic [9:0]    digit_ff;
   logic [7:0]    sum_ff;
   logic [3:0]    pend_ff, fault_ff;
   logic [7:0]    len_ff, type_ff, hb_ff, lb_ff;
   logic [15:0]   addr_ff;
   logic [3:0]    sticky_ff;
   logic          stopped_ff;
   logic [3:0]    code_ff;
   logic          special_ff;
   logic [32:0]   diff_ff;
   logic [7:0]    img_q_ff, rec_q_ff;
   logic          rd_ok_ff;
   logic [8:0]    copy_rd_ff, copy_len_ff;
   logic          pend_wr_ff;
   logic [IW-1:0] dst_ff, wr_addr_ff;
   logic          done_ff;
   logic [3:0]    lcode_ff;
   logic [7:0]    rdata_ff;

   logic          tc;
   logic [4:0]    hv;
   logic [3:0]    v;
   logic [7:0]    b;
   logic [8:0]    idx;
   logic [8:0]    ridx;
   logic          rec_wr;
   logic [9:0]    n;
   logic [7:0]    sum2;
   logic [3:0]    code1;
   logic          range_bad;
   logic [3:0]    final_code;
   logic          exec_ok;
   logic          copy_issue;
   logic          img_we;
   logic [IW-1:0] img_wa;
   logic [7:0]    img_wd;

   assign tc   = cmd.take_char && !req_tuser && c != CHAR_LF && !stopped_ff;
   assign hv   = hex_value(c);
   assign v    = hv[4] ? 4'd0 : hv[3:0];
   assign b    = {pend_ff, v};
   assign idx  = digit_ff[9:1];
   assign ridx = idx - 9'd4;
   assign rec_wr = tc && seen_ff && digit_ff != DIGIT_CAP && digit_ff[0] && idx >= 9'd4
                   && ridx < 9'(MAX_RECORD_BYTES);

   assign n    = digit_ff;
   assign sum2 = sum_ff + (n[0] ? {4'd0, pend_ff} : 8'd0);

   always_comb begin
      code1 = fault_ff;
      if (n[0]) code1 = CODE_ODD;
      if (sum2 != 8'd0) code1 = CODE_SUM;
      if (n >= DIGIT_CAP || n < EOF_DIGITS || {2'd0, len_ff} != ((n - 10'd9) >> 1)
          || {1'b0, len_ff} > 9'(MAX_RECORD_BYTES))
         code1 = CODE_LENGTH;
      if (bad_ff) code1 = CODE_DIGIT;
   end

   assign range_bad = diff_ff[32] ||
                      ({1'b0, diff_ff[31:0]} + {25'd0, len_ff}) > 33'(IMAGE_BYTES);
   assign exec_ok   = !special_ff && code_ff == CODE_OK;

   always_comb begin
      final_code = code_ff;
      if (exec_ok) begin
         if (type_ff == REC_DATA) begin
            if (range_bad) final_code = CODE_RANGE;
         end else if (type_ff != REC_UPPER && type_ff != REC_START) begin
            final_code = CODE_TYPE;
         end
      end
   end

   assign copy_issue = cmd.copy_step && copy_rd_ff != copy_len_ff;

   assign st.clear_last = clr_ff == IW'(IMAGE_BYTES - 1);
   assign st.item_read  = req_tuser;
   assign st.item_eol   = !req_tuser && c == CHAR_LF && !stopped_ff;
   assign st.copy_go    = exec_ok && type_ff == REC_DATA && !range_bad;
   assign st.copy_done  = copy_rd_ff == copy_len_ff && !pend_wr_ff;

   always_comb begin
      img_we = 1'b0;
      img_wa = wr_addr_ff;
      img_wd = rec_q_ff;
      if (cmd.clear_wr) begin
         img_we = 1'b1;
         img_wa = clr_ff;
         img_wd = ERASED;
      end else if (pend_wr_ff) begin
         img_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (img_we) image_mem[img_wa] <= img_wd;
      if (cmd.read_img) begin
         img_q_ff <= image_mem[IW'(read_addr)];
         rd_ok_ff <= {17'd0, read_addr} < 33'(IMAGE_BYTES);
      end
      if (rec_wr) rec_mem[RW'(ridx)] <= b;
      if (copy_issue) rec_q_ff <= rec_mem[RW'(copy_rd_ff)];
   end

   always_ff @(posedge clock) begin
      if (cmd.eval1) begin
         code_ff    <= !seen_ff ? CODE_EMPTY : ((eofm_ff && n == EOF_DIGITS) ? CODE_OK : code1);
         special_ff <= !seen_ff || (eofm_ff && n == EOF_DIGITS);
         diff_ff    <= {1'b0, upper_ff, addr_ff} - {1'b0, base_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         clr_ff     <= '0;
         upper_ff   <= '0;
         seen_ff    <= 1'b0;
         bad_ff     <= 1'b0;
         eofm_ff    <= 1'b0;
         digit_ff   <= '0;
         sum_ff     <= '0;
         pend_ff    <= '0;
         fault_ff   <= '0;
         len_ff     <= '0;
         addr_ff    <= '0;
         type_ff    <= '0;
         hb_ff      <= '0;
         lb_ff      <= '0;
         sticky_ff  <= '0;
         stopped_ff <= 1'b0;
         copy_rd_ff <= '0;
         copy_len_ff <= '0;
         pend_wr_ff <= 1'b0;
      end else begin
         if (csr_valid) base_ff <= csr_data;
         if (cmd.clear_wr) clr_ff <= clr_ff + 1'b1;
         if (tc) begin
            if (!seen_ff) begin
               seen_ff  <= 1'b1;
               fault_ff <= (c == CHAR_COLON) ? CODE_OK : CODE_COLON;
               eofm_ff  <= c == CHAR_COLON;
            end else begin
               eofm_ff <= eofm_ff && digit_ff < EOF_DIGITS && c == eof_next_char(digit_ff[3:0]);
               if (hv[4]) bad_ff <= 1'b1;
               if (digit_ff != DIGIT_CAP) begin
                  digit_ff <= digit_ff + 10'd1;
                  if (!digit_ff[0]) begin
                     pend_ff <= v;
                  end else begin
                     sum_ff <= sum_ff + b;
                     case (idx)
                        9'd0: len_ff <= b;
                        9'd1: addr_ff[15:8] <= b;
                        9'd2: addr_ff[7:0] <= b;
                        9'd3: type_ff <= b;
                        default: begin
                           if (ridx == {1'b0, len_ff} - 9'd2) hb_ff <= b;
                           if (ridx == {1'b0, len_ff} - 9'd1) lb_ff <= b;
                        end
                     endcase
                  end
               end
            end
         end
         if (cmd.eval2) begin
            if (special_ff) stopped_ff <= 1'b1;
            if (final_code != CODE_OK) sticky_ff <= final_code;
            if (exec_ok && type_ff == REC_UPPER) upper_ff <= {hb_ff, lb_ff};
            copy_rd_ff  <= '0;
            copy_len_ff <= {1'b0, len_ff};
            pend_wr_ff  <= 1'b0;
            seen_ff  <= 1'b0;
            bad_ff   <= 1'b0;
            eofm_ff  <= 1'b0;
            digit_ff <= '0;
            sum_ff   <= '0;
            pend_ff  <= '0;
            fault_ff <= '0;
            len_ff   <= '0;
            addr_ff  <= '0;
            type_ff  <= '0;
            hb_ff    <= '0;
            lb_ff    <= '0;
         end
         if (cmd.copy_step) begin
            pend_wr_ff <= copy_issue;
            if (copy_issue) copy_rd_ff <= copy_rd_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval2) dst_ff <= diff_ff[IW-1:0];
      if (copy_issue) wr_addr_ff <= dst_ff + IW'(copy_rd_ff);
      if (cmd.rsp_plain) begin
         done_ff  <= 1'b0;
         lcode_ff <= CODE_OK;
         rdata_ff <= 8'd0;
      end else if (cmd.rsp_read) begin
         done_ff  <= 1'b0;
         lcode_ff <= CODE_OK;
         rdata_ff <= rd_ok_ff ? img_q_ff : ERASED;
      end else if (cmd.eval2) begin
         done_ff  <= 1'b1;
         lcode_ff <= final_code;
         rdata_ff <= 8'd0;
      end
   end

   assign line_done    = done_ff;
   assign line_code    = lcode_ff;
   assign overall_code = sticky_ff;
   assign finished     = stopped_ff;
   assign read_data    = rdata_ff;

endmodule

FILE: rtl/core/ihex_ctrl.sv
// ----------------------------------------------------------------------------
// ihex_ctrl
// Controller: erase pass, item sequencing, line end and record copy steps.
// ----------------------------------------------------------------------------
module ihex_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output ihex_pkg::dp_cmd_type    cmd,
   input  ihex_pkg::dp_status_type st
);
   import ihex_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL1 = 3'd3;
   localparam logic [2:0] S_EVAL2 = 3'd4;
   localparam logic [2:0] S_COPY  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (st.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               if (st.item_read) begin
                  cmd.read_img = 1'b1;
                  state_in     = S_READ;
               end else if (st.item_eol) begin
                  state_in = S_EVAL1;
               end else begin
                  cmd.take_char = 1'b1;
                  cmd.rsp_plain = 1'b1;
                  state_in      = S_RESP;
               end
            end
         end
         S_READ: begin
            cmd.rsp_read = 1'b1;
            state_in     = S_RESP;
         end
         S_EVAL1: begin
            cmd.eval1 = 1'b1;
            state_in  = S_EVAL2;
         end
         S_EVAL2: begin
            cmd.eval2 = 1'b1;
            state_in  = st.copy_go ? S_COPY : S_RESP;
         end
         S_COPY: begin
            cmd.copy_step = 1'b1;
            if (st.copy_done) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = state_ff == S_RESP;

`ifndef SYNTH
   a_eval_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL1 |=> state_ff == S_EVAL2)
      else $error("line end evaluation out of order");
   a_copy_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY && st.copy_done) |=> state_ff == S_RESP)
      else $error("copy did not finish into response");
   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && st.clear_last) |=> state_ff == S_IDLE)
      else $error("erase pass did not end");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.read_img, cmd.eval1, cmd.eval2, cmd.copy_step}))
      else $error("conflicting datapath commands");
`endif

endmodule

FILE: rtl/core/intel_hex_image_loader_top.sv
// ----------------------------------------------------------------------------
// intel_hex_image_loader_top
// Hex text loader into a byte image with read back.
// ----------------------------------------------------------------------------
// After reset the image store is erased to 0xFF one byte per cycle, so the
// block accepts no item until the erase pass ends. A text character or a
// read is then taken as one item (accept, optional image read, result). A
// newline is evaluated and, for a valid data record, the record store is
// then copied into the image store through its single write port. One item
// is in work at a time; base_offset may be written on the csr channel
// whenever no item is pending.
module intel_hex_image_loader_top #(
   parameter int IMAGE_BYTES      = 65536,
   parameter int MAX_RECORD_BYTES = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_in[7:0], read_addr[23:8]
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // line_code[3:0], overall_code[7:4],
                                    // finished[8], read_data[16:9], zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import ihex_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;
   logic [3:0]    line_code, overall_code;
   logic          finished;
   logic [7:0]    read_data;

   ihex_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .st         (st)
   );

   ihex_dp #(
      .IMAGE_BYTES      (IMAGE_BYTES),
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .line_done    (rsp_tlast),
      .line_code    (line_code),
      .overall_code (overall_code),
      .finished     (finished),
      .read_data    (read_data)
   );

   assign csr_ready = 1'b1;
   assign rsp_tdata = {7'd0, read_data, finished, overall_code, line_code};

endmodule
